// ----- sv/dq_pkg.sv -----
package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int OCC_W          = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
    } in_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  popped;
        status_t                    status;
        logic [OCC_W-1:0]           occupancy;
        logic                       empty_res;
    } out_beat_t;

    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_back;
    } cell_ctrl_t;

endpackage

// ----- sv/double_ended_queue.sv -----
// Deque as a row of DEPTH shifting cells; the front entry always sits in cell 0.
// The result of an accepted input beat appears in the output register in the next cycle.
// Throughput: 1 beat per cycle; a stalled output holds the input off.
// Pop back reads the tail cell through a one-hot select across the row.
// Reset (rst_n low, async): deque empty, output register invalid; cell data is not cleared.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    out_beat_t                    out_beat_reg;
    out_beat_t                    out_beat_next;
    cell_ctrl_t                   ctrl;
    logic                         take;
    logic                         is_full;
    logic                         no_entries;
    status_t                      status;
    logic signed [DATA_WIDTH-1:0] push_word;
    logic signed [DATA_WIDTH-1:0] pop_word;
    logic signed [DATA_WIDTH-1:0] tail_word;
    logic signed [DATA_WIDTH-1:0] cell_word [DEPTH];
    logic signed [DATA_WIDTH-1:0] cell_tap  [DEPTH];

    assign in_stall   = out_valid_reg && out_stall;
    assign take       = in_valid && !in_stall;
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign no_entries = (count_reg == '0);
    assign push_word  = DATA_WIDTH'(in_beat.value);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] lower;
        logic signed [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = push_word;
        end
        else
        begin : g_mid_lo
            assign lower = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_word[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_word[i+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .push_word  (push_word),
            .from_lower (lower),
            .from_upper (upper),
            .word       (cell_word[i]),
            .tail_tap   (cell_tap[i])
        );
    end

    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | cell_tap[i];
        end
    end

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        status     = ST_OK;
        pop_word   = '0;
        if (take)
        begin
            unique case (in_beat.action)
                ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.push_front = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.push_back = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (no_entries)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.pop_front = 1'b1;
                        pop_word       = cell_word[0];
                        count_next     = count_reg - 1'b1;
                    end
                end
                ACT_POP_BACK:
                begin
                    if (no_entries)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop_word   = tail_word;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_beat_next.popped    = VALUE_W'(pop_word);
        out_beat_next.status    = status;
        out_beat_next.occupancy = OCC_W'(count_next);
        out_beat_next.empty_res = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (!in_stall)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_full
            && (in_beat.action == ACT_PUSH_FRONT || in_beat.action == ACT_PUSH_BACK)
        |=> out_beat_reg.status == ST_OVERFLOW && $stable(count_reg))
        else $error("full push not flagged or state changed");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        take && no_entries
            && (in_beat.action == ACT_POP_FRONT || in_beat.action == ACT_POP_BACK)
        |=> out_beat_reg.status == ST_UNDERFLOW && out_beat_reg.popped == '0
            && count_reg == '0)
        else $error("empty pop not flagged or state changed");

    a_occ_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_beat_reg.occupancy == OCC_W'(count_reg))
        else $error("reported occupancy differs from entry count");

endmodule

// ----- sv/dq_cell.sv -----
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
)
(
    input  logic                         clk,
    input  cell_ctrl_t                   ctrl,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [DATA_WIDTH-1:0] push_word,
    input  logic signed [DATA_WIDTH-1:0] from_lower,
    input  logic signed [DATA_WIDTH-1:0] from_upper,
    output logic signed [DATA_WIDTH-1:0] word,
    output logic signed [DATA_WIDTH-1:0] tail_tap
);

    logic signed [DATA_WIDTH-1:0] word_reg;
    logic signed [DATA_WIDTH-1:0] word_next;
    logic                         is_next_free;
    logic                         is_tail;

    assign is_next_free = (count == CNT_W'(INDEX));
    assign is_tail      = (count == CNT_W'(INDEX + 1));

    always_comb
    begin
        word_next = word_reg;
        priority if (ctrl.push_front)
        begin
            word_next = from_lower;
        end
        else if (ctrl.pop_front)
        begin
            word_next = from_upper;
        end
        else if (ctrl.push_back && is_next_free)
        begin
            word_next = push_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign tail_tap = is_tail ? word_reg : '0;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import dq_pkg::*;
();

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 60;
    localparam int DRILL_ROWS   = 24;

    typedef struct packed {
        action_t            act;
        logic signed [31:0] val;
        logic               given;
        out_beat_t          want;
    } drill_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_beat;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_beat;

    logic signed [VALUE_W-1:0] shadow_slots [DEPTH_DEF];
    int shadow_front = 0;
    int shadow_back  = 0;
    int shadow_count = 0;

    out_beat_t pending_replies [$];
    int        mismatch_count = 0;
    int        replies_seen   = 0;
    int        cycle_count    = 0;
    bit        tx_calm        = 0;
    bit        rx_calm        = 0;

    // empty pops, extremes in and out, then fill to full and overflow at both ends
    drill_row_t drill_rows [DRILL_ROWS] = '{
        '{ACT_POP_FRONT,  32'sd0,        1'b1, '{32'sd0, ST_UNDERFLOW, 5'd0, 1'b1}},
        '{ACT_POP_BACK,   32'sd0,        1'b1, '{32'sd0, ST_UNDERFLOW, 5'd0, 1'b1}},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'sd0, ST_OK, 5'd1, 1'b0}},
        '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'sd0, ST_OK, 5'd2, 1'b0}},
        '{ACT_POP_FRONT,  32'sd0,        1'b1, '{32'h8000_0000, ST_OK, 5'd1, 1'b0}},
        '{ACT_POP_BACK,   32'sd0,        1'b1, '{32'h7FFF_FFFF, ST_OK, 5'd0, 1'b1}},
        '{ACT_PUSH_FRONT, 32'sd1,        1'b0, '0},
        '{ACT_PUSH_BACK,  -32'sd1,       1'b0, '0},
        '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'sd0,        1'b0, '0},
        '{ACT_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'h8000_0001, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'h7FFF_FFFE, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'sd2,        1'b0, '0},
        '{ACT_PUSH_FRONT, -32'sd2,       1'b0, '0},
        '{ACT_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'h9ABC_DEF0, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'sd3,        1'b0, '0},
        '{ACT_PUSH_FRONT, 32'sd4,        1'b1, '{32'sd0, ST_OVERFLOW, 5'd16, 1'b0}},
        '{ACT_PUSH_BACK,  32'sd5,        1'b1, '{32'sd0, ST_OVERFLOW, 5'd16, 1'b0}}
    };

    double_ended_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int ring_up(int idx);
        return (idx == DEPTH_DEF - 1) ? 0 : idx + 1;
    endfunction

    function automatic int ring_down(int idx);
        return (idx == 0) ? DEPTH_DEF - 1 : idx - 1;
    endfunction

    function automatic out_beat_t deque_step(in_beat_t b);
        out_beat_t r;
        r = '0;
        case (b.action)
            ACT_PUSH_FRONT:
                if (shadow_count == DEPTH_DEF)
                    r.status = ST_OVERFLOW;
                else
                begin
                    shadow_front = ring_down(shadow_front);
                    shadow_slots[shadow_front] = b.value;
                    shadow_count++;
                end
            ACT_PUSH_BACK:
                if (shadow_count == DEPTH_DEF)
                    r.status = ST_OVERFLOW;
                else
                begin
                    shadow_slots[shadow_back] = b.value;
                    shadow_back = ring_up(shadow_back);
                    shadow_count++;
                end
            ACT_POP_FRONT:
                if (shadow_count == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    r.popped = shadow_slots[shadow_front];
                    shadow_front = ring_up(shadow_front);
                    shadow_count--;
                end
            default:
                if (shadow_count == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    shadow_back = ring_down(shadow_back);
                    r.popped = shadow_slots[shadow_back];
                    shadow_count--;
                end
        endcase
        r.occupancy = shadow_count[OCC_W-1:0];
        r.empty_res = (shadow_count == 0);
        return r;
    endfunction

    function automatic in_beat_t random_beat(int push_pct);
        in_beat_t b;
        int pick;
        if ($urandom_range(0, 99) < push_pct)
            b.action = ($urandom_range(0, 1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
            b.action = ($urandom_range(0, 1) == 0) ? ACT_POP_FRONT : ACT_POP_BACK;
        pick = $urandom_range(0, 11);
        case (pick)
            0:       b.value = 32'h8000_0000;
            1:       b.value = 32'h7FFF_FFFF;
            2:       b.value = '0;
            3:       b.value = '1;
            default: b.value = $urandom;
        endcase
        return b;
    endfunction

    task automatic offer_beat(input in_beat_t b, input logic given, input out_beat_t want);
        int gap;
        out_beat_t guess;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        guess = deque_step(b);
        pending_replies.push_back(given ? want : guess);
    endtask

    task automatic check_reply(input out_beat_t want, input out_beat_t got);
        if (got.popped !== want.popped)
        begin
            $error("popped: expected %0d, got %0d", want.popped, got.popped);
            mismatch_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.occupancy !== want.occupancy)
        begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            mismatch_count++;
        end
        if (got.empty_res !== want.empty_res)
        begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing pending");
                mismatch_count++;
            end
            else
                check_reply(pending_replies.pop_front(), out_beat);
        end
    end

    // receiver: random stalls per beat, calm stretches, one long hold-off
    initial
    begin
        int wait_cycles;
        int loops;
        bit held;
        held  = 0;
        loops = 0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (loops % 50 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            loops++;
            if (!held && replies_seen >= 300)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            wait_cycles = rx_calm ? 0 : $urandom_range(0, 6);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int push_pct;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        out_stall = 1'b0;
        push_pct  = 50;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill_rows[i])
            offer_beat('{drill_rows[i].act, drill_rows[i].val},
                       drill_rows[i].given, drill_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == 600)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_replies.size() != 0) @(posedge clk);
            end
            offer_beat(random_beat(push_pct), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dq_pkg.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
verif/testbench.sv
